@@ src/sha1_message_digest_macros.svh @@
// ---------------------------------------------------------------------------
// SHA-1 assertion macros
// Shared assertion forms for the checker.
// ---------------------------------------------------------------------------
`ifndef SHA1_MESSAGE_DIGEST_MACROS_SVH
`define SHA1_MESSAGE_DIGEST_MACROS_SVH

// implication checked every clock outside reset
`define SHA1_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication checked every clock outside reset
`define SHA1_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ src/sha1_pkg.sv @@
// ---------------------------------------------------------------------------
// SHA-1 package
// Constants, types and round functions shared by the SHA-1 block.
// ---------------------------------------------------------------------------
`default_nettype none

package sha1_pkg;

  localparam int unsigned DigestWords = 5;
  localparam int unsigned BlockWords  = 16;
  localparam int unsigned Rounds      = 80;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [7:0]  PadByte = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_PAD,
    ST_LEN,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic take_byte;   // store input byte
    logic pad_start;   // write 0x80 and zero rest
    logic clear_buf;   // zero buffer for length-only block
    logic load_len;    // put length into words 14 and 15
    logic round_start; // load working registers
    logic round_step;  // advance one round
    logic round_done;  // add into chain value
    logic out_shift;   // advance output word
    logic restart;     // return to initial state
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic block_full;  // 63 bytes buffered, next byte fills it
    logic last_round;  // round counter at 79
    logic pad_overflow;// padding needs a second block
    logic last_out;    // output on word four
  } status_t;

  function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    if (r < 7'd20) begin
      return (b & c) | (~b & d);
    end else if (r < 7'd40) begin
      return b ^ c ^ d;
    end else if (r < 7'd60) begin
      return (b & c) | (b & d) | (c & d);
    end
    return b ^ c ^ d;
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] r);
    if (r < 7'd20) begin
      return K0;
    end else if (r < 7'd40) begin
      return K1;
    end else if (r < 7'd60) begin
      return K2;
    end
    return K3;
  endfunction

endpackage

`default_nettype wire

@@ src/sha1_stream_if.sv @@
// ---------------------------------------------------------------------------
// SHA-1 stream interfaces
// Valid/ready channels for message bytes and digest words.
// ---------------------------------------------------------------------------
`default_nettype none

interface sha1_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] message_byte;
  logic       byte_present;
  logic       end_of_message;
  modport source (output valid, message_byte, byte_present, end_of_message, input ready);
  modport sink (input valid, message_byte, byte_present, end_of_message, output ready);
endinterface

interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

`default_nettype wire

@@ src/sha1_ctrl.sv @@
// ---------------------------------------------------------------------------
// SHA-1 controller
// Sequences byte intake, rounds, padding and digest output.
// ---------------------------------------------------------------------------
`default_nettype none

module sha1_ctrl (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  input  wire                in_present,
  input  wire                in_end,
  output logic               in_ready,
  input  wire                out_ready,
  output logic               out_valid,
  input  sha1_pkg::status_t  status,
  output sha1_pkg::cmd_t     cmd
);
  import sha1_pkg::*;

  state_t state, state_next;
  logic   pend_end, pend_end_next;   // end seen, padding still to do
  logic   pend_len, pend_len_next;   // length block still to do
  logic   final_blk, final_blk_next; // current rounds finish the message
  logic   acc, full_now;

  assign acc      = in_valid && in_ready;
  assign full_now = in_present && status.block_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pend_end  <= 1'b0;
      pend_len  <= 1'b0;
      final_blk <= 1'b0;
    end else begin
      state     <= state_next;
      pend_end  <= pend_end_next;
      pend_len  <= pend_len_next;
      final_blk <= final_blk_next;
    end
  end

  always_comb begin
    state_next     = state;
    pend_end_next  = pend_end;
    pend_len_next  = pend_len;
    final_blk_next = final_blk;
    unique case (state)
      ST_IDLE: begin
        if (acc) begin
          if (full_now) begin
            state_next     = ST_ROUND;
            pend_end_next  = in_end;
            final_blk_next = 1'b0;
          end else if (in_end) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        if (status.last_round) begin
          if (final_blk) begin
            state_next = ST_OUT;
          end else if (pend_len) begin
            state_next    = ST_LEN;
            pend_len_next = 1'b0;
          end else if (pend_end) begin
            state_next    = ST_PAD;
            pend_end_next = 1'b0;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_PAD: begin
        state_next = ST_ROUND;
        if (status.pad_overflow) begin
          pend_len_next  = 1'b1;
          final_blk_next = 1'b0;
        end else begin
          final_blk_next = 1'b1;
        end
      end
      ST_LEN: begin
        state_next     = ST_ROUND;
        final_blk_next = 1'b1;
      end
      ST_OUT: begin
        if (out_ready && status.last_out) begin
          state_next     = ST_IDLE;
          final_blk_next = 1'b0;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.take_byte = acc && in_present;
        cmd.round_start = acc && full_now;
      end
      ST_ROUND: begin
        cmd.round_step = 1'b1;
        cmd.round_done = status.last_round;
      end
      ST_PAD: begin
        cmd.pad_start   = 1'b1;
        cmd.load_len    = !status.pad_overflow;
        cmd.round_start = 1'b1;
      end
      ST_LEN: begin
        cmd.clear_buf   = 1'b1;
        cmd.load_len    = 1'b1;
        cmd.round_start = 1'b1;
      end
      ST_OUT: begin
        out_valid     = 1'b1;
        cmd.out_shift = out_ready;
        cmd.restart   = out_ready && status.last_out;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ src/sha1_datapath.sv @@
// ---------------------------------------------------------------------------
// SHA-1 datapath
// Block buffer, message schedule, round unit, chain value and length.
// ---------------------------------------------------------------------------
`default_nettype none

module sha1_datapath (
  input  wire                clk,
  input  wire                rst,
  input  wire  [7:0]         in_byte,
  input  sha1_pkg::cmd_t     cmd,
  output sha1_pkg::status_t  status,
  output logic [31:0]        digest_word,
  output logic [2:0]         word_index
);
  import sha1_pkg::*;

  logic [31:0] buf_w [BlockWords];
  logic [31:0] chain [DigestWords];
  logic [31:0] a, b, c, d, e;
  logic [5:0]  nbytes;
  logic [63:0] bitlen;
  logic [6:0]  rnd;
  logic [2:0]  oidx;
  logic [3:0]  bw;
  logic [1:0]  bb;
  logic [31:0] wnew, wcur, t;
  logic        pad_ovf;

  assign bw      = nbytes[5:2];
  assign bb      = nbytes[1:0];
  assign pad_ovf = nbytes >= 6'd56;
  assign wcur    = (rnd < 7'd16) ? buf_w[rnd[3:0]] : wnew;
  assign wnew    = {buf_w[13] ^ buf_w[8] ^ buf_w[2] ^ buf_w[0]} << 1 |
                   {31'd0, buf_w[13][31] ^ buf_w[8][31] ^ buf_w[2][31] ^ buf_w[0][31]};
  assign t       = {a[26:0], a[31:27]} + round_f(rnd, b, c, d) + e + round_k(rnd) + wcur;

  assign status.block_full   = nbytes == 6'd63;
  assign status.last_round   = rnd == 7'(Rounds - 1);
  assign status.pad_overflow = pad_ovf;
  assign status.last_out     = oidx == 3'(DigestWords - 1);

  assign digest_word = chain[oidx];
  assign word_index  = oidx;

  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      unique case (bb)
        2'd0: buf_w[bw] <= {in_byte, 24'd0};
        2'd1: buf_w[bw][23:16] <= in_byte;
        2'd2: buf_w[bw][15:8] <= in_byte;
        default: buf_w[bw][7:0] <= in_byte;
      endcase
    end else if (cmd.pad_start) begin
      for (int i = 0; i < BlockWords; i++) begin
        if (4'(i) > bw && (!cmd.load_len || i < BlockWords - 2)) begin
          buf_w[i] <= '0;
        end
      end
      unique case (bb)
        2'd0: buf_w[bw] <= {PadByte, 24'd0};
        2'd1: buf_w[bw][23:0] <= {PadByte, 16'd0};
        2'd2: buf_w[bw][15:0] <= {PadByte, 8'd0};
        default: buf_w[bw][7:0] <= PadByte;
      endcase
      if (cmd.load_len) begin
        buf_w[14] <= bitlen[63:32];
        buf_w[15] <= bitlen[31:0];
      end
    end else if (cmd.clear_buf) begin
      for (int i = 0; i < BlockWords - 2; i++) begin
        buf_w[i] <= '0;
      end
      buf_w[14] <= bitlen[63:32];
      buf_w[15] <= bitlen[31:0];
    end else if (cmd.round_step && rnd >= 7'd16) begin
      // slide the schedule window once the first 16 words are used
      for (int i = 0; i < BlockWords - 1; i++) begin
        buf_w[i] <= buf_w[i + 1];
      end
      buf_w[15] <= wnew;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.round_start) begin
      a <= chain[0]; b <= chain[1]; c <= chain[2]; d <= chain[3]; e <= chain[4];
    end else if (cmd.round_step) begin
      a <= t; b <= a; c <= {b[1:0], b[31:2]}; d <= c; e <= d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      chain[0] <= H0; chain[1] <= H1; chain[2] <= H2; chain[3] <= H3; chain[4] <= H4;
      nbytes   <= '0;
      bitlen   <= '0;
      rnd      <= '0;
      oidx     <= '0;
    end else begin
      if (cmd.take_byte) begin
        nbytes <= nbytes + 6'd1;
        bitlen <= bitlen + 64'd8;
      end
      if (cmd.round_start) begin
        rnd <= '0;
      end else if (cmd.round_step) begin
        rnd <= rnd + 7'd1;
      end
      if (cmd.round_done) begin
        chain[0] <= chain[0] + t;
        chain[1] <= chain[1] + a;
        chain[2] <= chain[2] + {b[1:0], b[31:2]};
        chain[3] <= chain[3] + c;
        chain[4] <= chain[4] + d;
      end
      if (cmd.out_shift) begin
        oidx <= oidx + 3'd1;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/sha1_message_digest.sv @@
// SHA-1 digest, one byte per transfer; each full block of 64 bytes then runs 80 rounds, one
// round per cycle in the shared round unit. The end of a message adds a block of padding
// rounds, or two blocks when the length needs a second block; five output words follow,
// the first in the cycle after the last round.
// Input is held off while rounds run and while the digest is handed out.
// Synchronous active-high reset restores the initial chain value and clears the counts.
// ---------------------------------------------------------------------------
// SHA-1 message digest top level
// Joins the controller and the datapath to the stream channels.
// ---------------------------------------------------------------------------
`default_nettype none

module sha1_message_digest (
  input  wire       clk,
  input  wire       rst,
  sha1_in_if.sink   in_ch,
  sha1_out_if.source out_ch
);
  import sha1_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready, out_valid;

  sha1_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_present (in_ch.byte_present),
    .in_end     (in_ch.end_of_message),
    .in_ready   (in_ready),
    .out_ready  (out_ch.ready),
    .out_valid  (out_valid),
    .status     (status),
    .cmd        (cmd)
  );

  sha1_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_byte     (in_ch.message_byte),
    .cmd         (cmd),
    .status      (status),
    .digest_word (out_ch.digest_word),
    .word_index  (out_ch.word_index)
  );

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid;
  assign out_ch.last_word = out_ch.word_index == 3'(DigestWords - 1);

endmodule

`default_nettype wire

@@ src/sha1_message_digest_checker.sv @@
// ---------------------------------------------------------------------------
// SHA-1 port checker
// Watches the top level channels for ordering and holding of digest words, and that input and output do not overlap.
// ---------------------------------------------------------------------------
`default_nettype none
`include "sha1_message_digest_macros.svh"

module sha1_message_digest_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [31:0] digest_word,
  input wire [2:0]  word_index,
  input wire        last_word
);
  `SHA1_ASSERT_IMPL(a_no_overlap, clk, rst, out_valid, !in_ready)
  `SHA1_ASSERT_IMPL(a_in_quiet, clk, rst, in_valid && in_ready, !out_valid)
  `SHA1_ASSERT_IMPL(a_last_match, clk, rst, out_valid, last_word == (word_index == 3'd4))
  `SHA1_ASSERT_NEXT(a_word_advance, clk, rst, out_valid && out_ready && !last_word,
                    out_valid && word_index == $past(word_index) + 3'd1)
  `SHA1_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready,
                    out_valid && $stable(digest_word) && $stable(word_index))
endmodule

bind sha1_message_digest sha1_message_digest_checker u_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .digest_word (out_ch.digest_word),
  .word_index  (out_ch.word_index),
  .last_word   (out_ch.last_word)
);

`default_nettype wire
